// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. All checks are disabled while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, p) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (p)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/stks_pkg.sv
`timescale 1ns / 1ps
package stks_pkg;

    localparam int MAX_KEEP_DEF   = 16;
    localparam int INDEX_BITS_DEF = 20;
    localparam int SCORE_W        = 32;
    localparam int CFG_W          = 5;
    localparam logic [CFG_W-1:0] KEEP_RESET = 5'd16;

endpackage

// File: hw/rtl/stks_insert.sv
`timescale 1ns / 1ps
// Sorted-list insert: parallel compare against every slot, then shift down.
module stks_insert #(
    parameter int MAX_KEEP   = stks_pkg::MAX_KEEP_DEF,
    parameter int INDEX_BITS = stks_pkg::INDEX_BITS_DEF,
    localparam int CNT_W     = $clog2(MAX_KEEP + 1),
    localparam int KIDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
    input  logic [INDEX_BITS-1:0]             slot_index [MAX_KEEP],
    input  logic signed [stks_pkg::SCORE_W-1:0] slot_score [MAX_KEEP],
    input  logic [CNT_W-1:0]                  fill,
    input  logic [CNT_W-1:0]                  keep,
    input  logic [INDEX_BITS-1:0]             new_index,
    input  logic signed [stks_pkg::SCORE_W-1:0] new_score,
    output logic [INDEX_BITS-1:0]             next_index [MAX_KEEP],
    output logic signed [stks_pkg::SCORE_W-1:0] next_score [MAX_KEEP],
    output logic [CNT_W-1:0]                  next_fill
);

    logic [CNT_W-1:0]  fill_eff;
    logic [CNT_W-1:0]  keep_m1;
    logic [CNT_W-1:0]  len;
    logic              room;
    logic              beat;
    logic              ins;
    logic [MAX_KEEP-1:0] stay;

    always_comb
    begin
        fill_eff = (fill > keep) ? keep : fill;
        keep_m1  = keep - CNT_W'(1);
        room     = (fill_eff < keep);
        // strictly greater than the current minimum of a full list
        beat     = (new_score > slot_score[keep_m1[KIDX_W-1:0]]);
        ins      = room || beat;
        len      = room ? fill_eff : keep_m1;
        next_fill = room ? (fill_eff + CNT_W'(1)) : fill_eff;
    end

    // entries at or above the new score stay ahead (earlier index wins ties)
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            stay[i] = (CNT_W'(i) < len) && (slot_score[i] >= new_score);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            if (!ins || stay[i])
            begin
                next_index[i] = slot_index[i];
                next_score[i] = slot_score[i];
            end
            else if (i == 0)
            begin
                next_index[i] = new_index;
                next_score[i] = new_score;
            end
            else if (stay[i-1])
            begin
                next_index[i] = new_index;
                next_score[i] = new_score;
            end
            else
            begin
                next_index[i] = slot_index[i-1];
                next_score[i] = slot_score[i-1];
            end
        end
    end

endmodule

// File: hw/rtl/streaming_top_k_select.sv
`timescale 1ns / 1ps
// Streaming top-k selection. Accepts one score word per cycle while in_ready
// is high, numbers the words of a batch from 0 and keeps the best keep_count
// (index, score) pairs sorted best first; a full list takes a new score only
// if it is strictly greater than the current minimum, ties keep the earlier
// index ahead. The word flagged last_in is ranked too, then the whole list is
// copied into an output bank and drained one result word per cycle while
// out_ready is high, best first, with last_out on the final one; the next
// batch streams in meanwhile. A word sits in the input register and is ranked
// from there into the slot registers. Sustained rate is one word per cycle,
// set by the compare-and-shift of the slot registers; a last_in word waits in
// the input register until the output bank is empty or the final word of the
// previous batch leaves in the same cycle. Slots live in flip-flops with no
// reset and no clearing pass; the index counter saturates at its maximum.
// keep_count of 0 acts as 1, above MAX_KEEP as MAX_KEEP; the user must write
// it only while the block is idle, which the block itself does not enforce.
`include "assert_macros.svh"

module streaming_top_k_select #(
    parameter int MAX_KEEP   = stks_pkg::MAX_KEEP_DEF,
    parameter int INDEX_BITS = stks_pkg::INDEX_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration: keep_count
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stks_pkg::CFG_W-1:0]          cfg_data,
    // score stream
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [stks_pkg::SCORE_W-1:0] score,
    input  logic                                last_in,
    // result stream
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [INDEX_BITS-1:0]               example_index,
    output logic signed [stks_pkg::SCORE_W-1:0] kept_score,
    output logic                                last_out
);

    localparam int CNT_W = $clog2(MAX_KEEP + 1);
    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

    logic [stks_pkg::CFG_W-1:0] keep_count_reg;
    logic [CNT_W-1:0]           keep_eff;

    // input register
    logic                                in_vld_reg;
    logic signed [stks_pkg::SCORE_W-1:0] in_score_reg;
    logic                                in_last_reg;

    // working list
    logic [INDEX_BITS-1:0]               slot_index_reg [MAX_KEEP];
    logic signed [stks_pkg::SCORE_W-1:0] slot_score_reg [MAX_KEEP];
    logic [CNT_W-1:0]                    fill_reg;
    logic [INDEX_BITS-1:0]               arrival_reg;

    logic [INDEX_BITS-1:0]               slot_index_next [MAX_KEEP];
    logic signed [stks_pkg::SCORE_W-1:0] slot_score_next [MAX_KEEP];
    logic [CNT_W-1:0]                    fill_next;

    // output bank; entry 0 is the result register
    logic [INDEX_BITS-1:0]               snap_index_reg [MAX_KEEP];
    logic signed [stks_pkg::SCORE_W-1:0] snap_score_reg [MAX_KEEP];
    logic [CNT_W-1:0]                    snap_cnt_reg;

    logic out_fire;
    logic snap_free;
    logic proc;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        int k;
        k = int'(keep_count_reg);
        if (k < 1)
        begin
            k = 1;
        end
        if (k > MAX_KEEP)
        begin
            k = MAX_KEEP;
        end
        keep_eff = CNT_W'(k);
    end

    assign out_valid     = (snap_cnt_reg != '0);
    assign out_fire      = out_valid && out_ready;
    assign example_index = snap_index_reg[0];
    assign kept_score    = snap_score_reg[0];
    assign last_out      = (snap_cnt_reg == CNT_W'(1));

    // bank can take a new batch once at most its final word remains and leaves
    assign snap_free = (snap_cnt_reg == '0) || (last_out && out_ready);
    assign proc      = in_vld_reg && (!in_last_reg || snap_free);
    assign in_ready  = !in_vld_reg || proc;

    stks_insert #(
        .MAX_KEEP   (MAX_KEEP),
        .INDEX_BITS (INDEX_BITS)
    ) u_insert (
        .slot_index (slot_index_reg),
        .slot_score (slot_score_reg),
        .fill       (fill_reg),
        .keep       (keep_eff),
        .new_index  (arrival_reg),
        .new_score  (in_score_reg),
        .next_index (slot_index_next),
        .next_score (slot_score_next),
        .next_fill  (fill_next)
    );

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= stks_pkg::KEEP_RESET;
            in_vld_reg     <= 1'b0;
            fill_reg       <= '0;
            arrival_reg    <= '0;
            snap_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                keep_count_reg <= cfg_data;
            end
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (proc)
            begin
                if (in_last_reg)
                begin
                    fill_reg    <= '0;
                    arrival_reg <= '0;
                end
                else
                begin
                    fill_reg <= fill_next;
                    if (arrival_reg != IDX_MAX)
                    begin
                        arrival_reg <= arrival_reg + INDEX_BITS'(1);
                    end
                end
            end
            if (proc && in_last_reg)
            begin
                snap_cnt_reg <= fill_next;
            end
            else if (out_fire)
            begin
                snap_cnt_reg <= snap_cnt_reg - CNT_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_score_reg <= score;
            in_last_reg  <= last_in;
        end
        if (proc)
        begin
            slot_index_reg <= slot_index_next;
            slot_score_reg <= slot_score_next;
        end
        if (proc && in_last_reg)
        begin
            snap_index_reg <= slot_index_next;
            snap_score_reg <= slot_score_next;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_KEEP - 1; i++)
            begin
                snap_index_reg[i] <= snap_index_reg[i+1];
                snap_score_reg[i] <= snap_score_reg[i+1];
            end
        end
    end

    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= CNT_W'(MAX_KEEP))
    `ASSERT_ALWAYS(a_snap_bound, clk, rst_n, snap_cnt_reg <= CNT_W'(MAX_KEEP))
    `ASSERT_NEXT(a_last_clears, clk, rst_n, proc && in_last_reg,
                 fill_reg == '0 && arrival_reg == '0 && out_valid)
    `ASSERT_NEXT(a_arrival_step, clk, rst_n,
                 proc && !in_last_reg && arrival_reg != IDX_MAX,
                 arrival_reg == $past(arrival_reg) + INDEX_BITS'(1))
    `ASSERT_SAME(a_no_overrun, clk, rst_n, proc && in_last_reg && out_valid,
                 last_out && out_ready)

endmodule

// File: bench/streaming_top_k_select_test.sv
`timescale 1ns / 1ps
module streaming_top_k_select_test;

    localparam int MAX_KEEP       = stks_pkg::MAX_KEEP_DEF;
    localparam int INDEX_BITS     = stks_pkg::INDEX_BITS_DEF;
    localparam int SCORE_W        = stks_pkg::SCORE_W;
    localparam int CFG_W          = stks_pkg::CFG_W;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    localparam int DIRECTED_ROWS  = 24;
    localparam int RANDOM_WORDS   = 386;
    localparam int SETTLE_CYCLES  = 8;     // lets the last accepted word be ranked
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 5000;  // cycles without any handshake
    localparam int PRINT_LIMIT    = 40;

    // One kept (index, score) pair as it leaves the block.
    typedef struct packed {
        logic [INDEX_BITS-1:0]    idx;
        logic signed [SCORE_W-1:0] value;
        logic                     tail;
    } pair_t;

    // Directed row: optional keep_count write before the word, the word
    // itself, and a typed-in single result where it is obvious.
    typedef struct packed {
        logic                     cfg;
        logic [CFG_W-1:0]         keep;
        logic signed [SCORE_W-1:0] score;
        logic                     last;
        logic                     typed;
        logic [INDEX_BITS-1:0]    t_index;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SCORE_W-1:0]  score = '0;
    logic                       last_in = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [INDEX_BITS-1:0]      example_index;
    logic signed [SCORE_W-1:0]  kept_score;
    logic                       last_out;

    // Shadow of the ranking state.
    logic [INDEX_BITS-1:0]      kept_idx [MAX_KEEP];
    logic signed [SCORE_W-1:0]  kept_val [MAX_KEEP];
    int                         kept_fill = 0;
    logic [INDEX_BITS-1:0]      next_index = '0;
    logic [CFG_W-1:0]           keep_reg = stks_pkg::KEEP_RESET;

    pair_t                      kept_pairs_due [$];
    stim_row_t                  directed_rows [DIRECTED_ROWS];
    int                         mismatches = 0;
    bit                         quiet = 1'b0;     // no idling on either side
    bit                         hold_req = 1'b0;  // ask receiver for a long hold-off

    streaming_top_k_select i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .score         (score),
        .last_in       (last_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .example_index (example_index),
        .kept_score    (kept_score),
        .last_out      (last_out)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // keep_count choice, biased toward the extremes and the clamp region.
    function automatic logic [CFG_W-1:0] pick_keep();
        case ($urandom_range(0, 5))
            0:       return 5'd1;
            1:       return 5'd16;
            2:       return ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0;
            default: return CFG_W'($urandom_range(0, 31));
        endcase
    endfunction

    // Rank one accepted word into the shadow list. On last_in the whole
    // list is queued best first, then the batch state clears. With emit
    // low only the state moves (the row carries its own typed result).
    task automatic rank_score(input logic signed [SCORE_W-1:0] s, input bit fin,
                              input bit emit);
        int k;
        int len;
        int pos;
        int i;
        k = (keep_reg < 1) ? 1 : ((keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg));
        // keep_count lowered in mid batch: drop the lowest pairs first
        if (kept_fill > k)
            kept_fill = k;
        len = -1;
        if (kept_fill < k)
        begin
            len = kept_fill;
            kept_fill++;
        end
        else if (s > kept_val[k-1])
        begin
            // full list: strictly greater than the minimum, minimum falls off
            len = k - 1;
        end
        if (len >= 0)
        begin
            // shift only past strictly smaller scores, so ties keep order
            pos = len;
            while (pos > 0 && kept_val[pos-1] < s)
            begin
                kept_val[pos] = kept_val[pos-1];
                kept_idx[pos] = kept_idx[pos-1];
                pos--;
            end
            kept_val[pos] = s;
            kept_idx[pos] = next_index;
        end
        // counter sticks at its top value once there
        if (next_index != INDEX_MAX)
            next_index++;
        if (fin)
        begin
            if (emit)
                for (i = 0; i < kept_fill; i++)
                    kept_pairs_due.push_back({kept_idx[i], kept_val[i], i + 1 == kept_fill});
            kept_fill = 0;
            next_index = '0;
        end
    endtask

    // Offer one word; returns at the edge that accepts it. Valid is only
    // dropped when a gap is taken, never lowered and raised in one step.
    task automatic send_word(input logic signed [SCORE_W-1:0] s, input bit fin);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        score    <= s;
        last_in  <= fin;
        do @(posedge clk); while (!in_ready);
    endtask

    // keep_count write: only once every due result is out and the last
    // word has had time to be ranked.
    task automatic write_keep(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (kept_pairs_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        keep_reg = value;
    endtask

    // Directed table. Typed results are one word batches or a batch whose
    // winner is plain to see; all others go through rank_score.
    initial
    begin
        // one word right after reset, default keep_count
        directed_rows[0]  = {1'b0, 5'd0,  32'sh0001_0000, 1'b1, 1'b1, 20'd0};
        // score extremes
        directed_rows[1]  = {1'b0, 5'd0,  32'sh7FFF_FFFF, 1'b1, 1'b1, 20'd0};
        directed_rows[2]  = {1'b0, 5'd0,  32'sh8000_0000, 1'b1, 1'b1, 20'd0};
        // equal scores: earlier index stays ahead
        directed_rows[3]  = {1'b0, 5'd0,  32'sd3,         1'b0, 1'b0, 20'd0};
        directed_rows[4]  = {1'b0, 5'd0,  32'sd3,         1'b0, 1'b0, 20'd0};
        directed_rows[5]  = {1'b0, 5'd0,  32'sd5,         1'b0, 1'b0, 20'd0};
        directed_rows[6]  = {1'b0, 5'd0,  32'sd3,         1'b1, 1'b0, 20'd0};
        // keep two: below minimum, tie at minimum, replacement
        directed_rows[7]  = {1'b1, 5'd2,  32'sd10,        1'b0, 1'b0, 20'd0};
        directed_rows[8]  = {1'b0, 5'd0,  32'sd20,        1'b0, 1'b0, 20'd0};
        directed_rows[9]  = {1'b0, 5'd0,  32'sd5,         1'b0, 1'b0, 20'd0};
        directed_rows[10] = {1'b0, 5'd0,  32'sd10,        1'b0, 1'b0, 20'd0};
        directed_rows[11] = {1'b0, 5'd0,  32'sd30,        1'b1, 1'b0, 20'd0};
        // keep_count 0 acts as 1: the larger second word wins
        directed_rows[12] = {1'b1, 5'd0,  32'sd5,         1'b0, 1'b0, 20'd0};
        directed_rows[13] = {1'b0, 5'd0,  32'sd9,         1'b1, 1'b1, 20'd1};
        // keep_count 31 clamps to the slot count
        directed_rows[14] = {1'b1, 5'd31, 32'shFFFF_FFFF, 1'b0, 1'b0, 20'd0};
        directed_rows[15] = {1'b0, 5'd0,  32'sh8000_0000, 1'b0, 1'b0, 20'd0};
        directed_rows[16] = {1'b0, 5'd0,  32'sd0,         1'b0, 1'b0, 20'd0};
        directed_rows[17] = {1'b0, 5'd0,  32'sh7FFF_FFFF, 1'b1, 1'b0, 20'd0};
        // keep four, then lowered to one in mid batch
        directed_rows[18] = {1'b1, 5'd4,  32'sd100,       1'b0, 1'b0, 20'd0};
        directed_rows[19] = {1'b0, 5'd0,  32'sd200,       1'b0, 1'b0, 20'd0};
        directed_rows[20] = {1'b0, 5'd0,  32'sd300,       1'b0, 1'b0, 20'd0};
        directed_rows[21] = {1'b0, 5'd0,  32'sd400,       1'b0, 1'b0, 20'd0};
        directed_rows[22] = {1'b1, 5'd1,  32'sd250,       1'b1, 1'b0, 20'd0};
        // keep_count 17, one word
        directed_rows[23] = {1'b1, 5'd17, 32'sd7,         1'b1, 1'b1, 20'd0};
    end

    // Result receiver: random ready gaps, plus one long hold-off on request.
    initial
    begin : receiver
        int gap;
        int run;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = quiet ? 0 : pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run) @(posedge clk);
        end
    end

    // Every accepted result word against the oldest pair due.
    always @(posedge clk)
    begin : check_results
        pair_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (kept_pairs_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: result word with none due: index %0d score %0d last %0b",
                             $time, example_index, kept_score, last_out);
            end
            else
            begin
                due = kept_pairs_due.pop_front();
                if (example_index !== due.idx || kept_score !== due.value ||
                    last_out !== due.tail)
                begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t: expected index %0d score %0d last %0b, got %0d %0d %0b",
                                 $time, due.idx, due.value, due.tail,
                                 example_index, kept_score, last_out);
                end
            end
        end
    end

    // Watchdog: too long with no handshake on any channel.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("streaming_top_k_select_test: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t              row;
        logic signed [SCORE_W-1:0] s;
        int                     r;
        int                     n;
        int                     len;
        int                     remaining;
        int                     batch_no;
        bit                     tie_mode;
        bit                     pressing;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = directed_rows[r];
            if (row.cfg)
                write_keep(row.keep);
            send_word(row.score, row.last);
            rank_score(row.score, row.last, !row.typed);
            if (row.typed)
                kept_pairs_due.push_back({row.t_index, row.score, 1'b1});
        end

        // random batches; batches 2..9 run flat out while the receiver
        // holds off, so the result bank fills and input backs up
        remaining = RANDOM_WORDS;
        batch_no = 0;
        while (remaining > 0)
        begin
            pressing = (batch_no >= 2 && batch_no < 10);
            quiet = pressing || ($urandom_range(0, 4) == 0);
            if (batch_no == 2)
                hold_req = 1'b1;
            if (!pressing && $urandom_range(0, 3) == 0)
                write_keep(pick_keep());
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
            if (pressing && len < 2)
                len = 2;
            tie_mode = ($urandom_range(0, 3) == 0);
            for (n = 0; n < len; n++)
            begin
                // occasional keep_count change with the batch half done
                if (!pressing && n == len / 2 && n > 0 && $urandom_range(0, 7) == 0)
                    write_keep(pick_keep());
                s = tie_mode ? SCORE_W'($urandom_range(0, 3) - 2) : SCORE_W'($urandom);
                send_word(s, n == len - 1);
                rank_score(s, n == len - 1, 1'b1);
            end
            remaining -= len;
            batch_no++;
        end
        in_valid <= 1'b0;

        while (kept_pairs_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && kept_pairs_due.size() == 0)
            $display("streaming_top_k_select_test: done, clean");
        else
            $display("streaming_top_k_select_test: done, errors");
        $finish;
    end

endmodule
